// ===== hw/rtl/psc_pkg.sv =====
`timescale 1ns / 1ps

package psc_pkg;

  localparam int CoefW  = 16;
  localparam int CountW = 10;
  localparam int PcW    = 19;
  localparam int KpaW   = 15;
  localparam int IdxW   = 3;

  // kPa = 12800 + 16*c + floor((272*c + 511) / 1023), since 16640 = 16*1023 + 272
  localparam int unsigned KpaBase  = 12800;
  localparam int unsigned KpaRound = 511;
  localparam int unsigned KpaRecip = 524801;  // ceil(2^29 / 1023)
  localparam int unsigned KpaShift = 29;
  localparam int unsigned CountMax = 1023;

  typedef enum logic [IdxW-1:0] {
    REG_A0  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_C12 = 3'd3,
    REG_C11 = 3'd4,
    REG_C22 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoefW-1:0] a0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] c12;
    logic signed [CoefW-1:0] c11;
    logic signed [CoefW-1:0] c22;
  } coef_t;

  // polynomial result handed to the kPa stages
  typedef struct packed {
    logic                  valid;
    logic signed [PcW-1:0] pc;
    logic [CountW-1:0]     clamp_val;
    logic                  clip;
  } poly_res_t;

endpackage

// ===== hw/rtl/psc_if.sv =====
`timescale 1ns / 1ps

interface psc_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] pressure_count;
  logic [9:0] temperature_count;

  modport source (output valid, output pressure_count, output temperature_count, input ready);
  modport sink   (input valid, input pressure_count, input temperature_count, output ready);
endinterface

interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] compensated_count;
  logic [14:0]        pressure_kpa_q8;
  logic               clamped;

  modport source (output valid, output compensated_count, output pressure_kpa_q8,
                  output clamped, input ready);
  modport sink   (input valid, input compensated_count, input pressure_kpa_q8,
                  input clamped, output ready);
endinterface

// ===== hw/rtl/psc_cfg_regs.sv =====
`timescale 1ns / 1ps

module psc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psc_pkg::IdxW-1:0]      cfg_index,
  input  logic [psc_pkg::CoefW-1:0]     cfg_wdata,
  output psc_pkg::coef_t                coef
);
  import psc_pkg::*;

  coef_t coef_r, coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_A0:  coef_nxt.a0  = cfg_wdata;
        REG_B1:  coef_nxt.b1  = cfg_wdata;
        REG_B2:  coef_nxt.b2  = cfg_wdata;
        REG_C12: coef_nxt.c12 = cfg_wdata;
        REG_C11: coef_nxt.c11 = cfg_wdata;
        REG_C22: coef_nxt.c22 = cfg_wdata;
        default: coef_nxt = coef_r;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

// ===== hw/rtl/psc_poly.sv =====
`timescale 1ns / 1ps

module psc_poly (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [psc_pkg::CountW-1:0]    in_p,
  input  logic [psc_pkg::CountW-1:0]    in_t,
  input  psc_pkg::coef_t                coef,
  output psc_pkg::poly_res_t            res
);
  import psc_pkg::*;

  // stage 1: a11, c12*T, a2
  logic                     v1_r;
  logic [CountW-1:0]        p1_r, t1_r;
  logic signed [17:0]       a11_1_r, a11_1_nxt;
  logic signed [25:0]       c12t_1_r, c12t_1_nxt;
  logic signed [16:0]       a2_1_r, a2_1_nxt;
  // stage 2: a1
  logic                     v2_r;
  logic [CountW-1:0]        p2_r, t2_r;
  logic signed [18:0]       a1_2_r, a1_2_nxt;
  logic signed [16:0]       a2_2_r;
  // stage 3: y1, a2*T
  logic                     v3_r;
  logic signed [18:0]       y1_3_r, y1_3_nxt;
  logic signed [25:0]       a2t_3_r, a2t_3_nxt;
  // stage 4: Pc, clamp
  poly_res_t                res_r, res_nxt;

  logic signed [31:0] p_x, t_x, c11p, c12t, c22t, sum11, sum2;
  logic signed [31:0] sum1, p2_x, t2_x, a1p, sumy, a2t;
  logic signed [31:0] s, q;

  always_comb begin
    p_x        = {22'd0, in_p};
    t_x        = {22'd0, in_t};
    c11p       = 32'(coef.c11) * p_x;
    c12t       = 32'(coef.c12) * t_x;
    c22t       = 32'(coef.c22) * t_x;
    sum11      = (32'(coef.b1) <<< 14) + c11p;
    sum2       = (32'(coef.b2) <<< 15) + (c22t >>> 1);
    a11_1_nxt  = 18'(sum11 >>> 14);
    c12t_1_nxt = 26'(c12t);
    a2_1_nxt   = 17'(sum2 >>> 16);

    sum1       = (32'(a11_1_r) <<< 11) + 32'(c12t_1_r);
    a1_2_nxt   = 19'(sum1 >>> 11);

    p2_x       = {22'd0, p2_r};
    t2_x       = {22'd0, t2_r};
    a1p        = 32'(a1_2_r) * p2_x;
    sumy       = (32'(coef.a0) <<< 10) + a1p;
    y1_3_nxt   = 19'(sumy >>> 10);
    a2t        = 32'(a2_2_r) * t2_x;
    a2t_3_nxt  = 26'(a2t);

    s = (32'(y1_3_r) <<< 10) + 32'(a2t_3_r);
    q = s >>> 13;
    // division truncates toward zero: bump negative values with a remainder
    if (s[31] && (s[12:0] != 13'd0)) begin
      q = q + 32'sd1;
    end
    res_nxt.valid = v3_r;
    res_nxt.pc    = PcW'(q);
    res_nxt.clip  = (q < 32'sd0) || (q > 32'(CountMax));
    if (q < 32'sd0) begin
      res_nxt.clamp_val = '0;
    end else if (q > 32'(CountMax)) begin
      res_nxt.clamp_val = CountW'(CountMax);
    end else begin
      res_nxt.clamp_val = q[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      p1_r     <= in_p;
      t1_r     <= in_t;
      a11_1_r  <= a11_1_nxt;
      c12t_1_r <= c12t_1_nxt;
      a2_1_r   <= a2_1_nxt;
      p2_r     <= p1_r;
      t2_r     <= t1_r;
      a1_2_r   <= a1_2_nxt;
      a2_2_r   <= a2_1_r;
      y1_3_r   <= y1_3_nxt;
      a2t_3_r  <= a2t_3_nxt;
      res_r    <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/psc_kpa.sv =====
`timescale 1ns / 1ps

module psc_kpa (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  psc_pkg::poly_res_t res,
  psc_out_if.source          out_ch
);
  import psc_pkg::*;

  localparam int MW = 19;
  localparam int RW = 20;

  // stage 5: reciprocal multiply for the /1023
  logic                  v5_r;
  logic signed [PcW-1:0] pc5_r;
  logic [CountW-1:0]     c5_r;
  logic                  clip5_r;
  logic [CountW-1:0]     qs5_r, qs5_nxt;
  // stage 6: output register
  logic                  v6_r;
  logic signed [PcW-1:0] pc6_r;
  logic [KpaW-1:0]       kpa6_r, kpa6_nxt;
  logic                  clip6_r;

  logic [MW-1:0]    m;
  logic [MW+RW-1:0] prod;

  always_comb begin
    m        = {1'b0, res.clamp_val, 8'd0} + {5'd0, res.clamp_val, 4'd0} + MW'(KpaRound);
    prod     = {{RW{1'b0}}, m} * {{MW{1'b0}}, RW'(KpaRecip)};
    qs5_nxt  = prod[KpaShift +: CountW];
    kpa6_nxt = KpaW'(KpaBase) + {1'b0, c5_r, 4'd0} + {5'd0, qs5_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v5_r <= res.valid;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc5_r   <= res.pc;
      c5_r    <= res.clamp_val;
      clip5_r <= res.clip;
      qs5_r   <= qs5_nxt;
      pc6_r   <= pc5_r;
      kpa6_r  <= kpa6_nxt;
      clip6_r <= clip5_r;
    end
  end

  assign out_ch.valid             = v6_r;
  assign out_ch.compensated_count = pc6_r;
  assign out_ch.pressure_kpa_q8   = kpa6_r;
  assign out_ch.clamped           = clip6_r;

endmodule

// ===== hw/rtl/pressure_sensor_compensation.sv =====
// Throughput: one request per cycle while the pipeline advances; the six-stage
// pipeline (four for the polynomial, two for the kPa conversion) advances
// whenever the output register is empty or being drained, so a stall holds
// every stage.
// Reset (synchronous, rst_n low) clears all stage valid bits and the six
// coefficient registers to zero.
`timescale 1ns / 1ps

module pressure_sensor_compensation (
  input  logic                          clk,
  input  logic                          rst_n,
  psc_in_if.sink                        in_ch,
  psc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [psc_pkg::IdxW-1:0]      cfg_index,
  input  logic [psc_pkg::CoefW-1:0]     cfg_wdata
);
  import psc_pkg::*;

  coef_t     coef;
  poly_res_t res;
  logic      adv;

  assign adv         = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = adv;

  psc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  psc_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_p     (in_ch.pressure_count),
    .in_t     (in_ch.temperature_count),
    .coef     (coef),
    .res      (res)
  );

  psc_kpa u_kpa (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .res    (res),
    .out_ch (out_ch)
  );

endmodule
